### hw/rtl/atn_pkg.sv
// Shared types, constants and helpers for the arctangent pipeline.
// No dependencies; every other file imports this package.
package atn_pkg;

  localparam int DEF_COORD_WIDTH     = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  // ratio t is unsigned Q1.15 within [0, 1]
  localparam int RATIO_W    = 16;
  localparam int RATIO_FRAC = 15;
  localparam int PROD_W     = 2 * RATIO_W;

  // pi in Q3.61
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  // Horner coefficients in Q1.15, innermost first
  localparam logic [RATIO_W-1:0] COEF_INNER = 16'd683;
  localparam logic [RATIO_W-1:0] HORNER_C [0:3] = '{16'd2790, 16'd5903, 16'd10823, 16'd32764};

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic xzero;
    logic yzero;
    logic swap;   // |y| > |x|: ratio is x/y, reflect about half pi
  } side_t;

  typedef struct packed {
    logic  valid;
    side_t side;
  } ctl_t;

  // round a Q2.30 product back to Q1.15, half up
  function automatic logic [RATIO_W-1:0] rnd15(input logic [PROD_W-1:0] v);
    logic [PROD_W:0] sum;
    sum = {1'b0, v} + (PROD_W + 1)'(1 << (RATIO_FRAC - 1));
    return sum[RATIO_FRAC +: RATIO_W];
  endfunction

  // pi scaled down from Q3.61 by a right shift, rounded to nearest
  function automatic logic [63:0] scaled_pi(input int unsigned shift);
    return (PI_Q61 + (64'd1 << (shift - 1))) >> shift;
  endfunction

endpackage

### hw/rtl/arctangent2_approx.sv
// Four-quadrant arctangent of a signed (y, x) pair, angle in Q3.ANGLE_FRAC_BITS.
// Pipeline stages from input transfer to result: 1 prep, 17 divider,
// 6 polynomial, 4 output. Throughput: one pair per cycle while no result is held.
// An output stall holds every stage; in_stall follows out_valid and out_stall.
// Synchronous active-low reset clears the valid bits only.
module arctangent2_approx #(
  parameter int COORD_WIDTH     = atn_pkg::DEF_COORD_WIDTH,
  parameter int ANGLE_FRAC_BITS = atn_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_y_coord,
  input  logic signed [COORD_WIDTH-1:0]     in_x_coord,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ANGLE_FRAC_BITS+2:0] out_angle
);
  import atn_pkg::*;

  logic                     en;
  ctl_t                     prep_ctl, div_ctl, poly_ctl;
  logic [COORD_WIDTH-1:0]   min_w, max_w;
  logic [RATIO_W-1:0]       t_w;
  logic [PROD_W-1:0]        prod_w;
  logic [ANGLE_FRAC_BITS+2:0] angle_w;

  // advance everything unless a finished result is being held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  atn_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .y_coord(in_y_coord), .x_coord(in_x_coord),
    .ctl_o(prep_ctl), .min_o(min_w), .max_o(max_w)
  );

  atn_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(prep_ctl),
    .min_i(min_w), .max_i(max_w), .ctl_o(div_ctl), .t_o(t_w)
  );

  atn_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(div_ctl),
    .t_i(t_w), .ctl_o(poly_ctl), .prod_o(prod_w)
  );

  atn_fin #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fin (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(poly_ctl),
    .prod_i(prod_w), .valid_o(out_valid), .angle_o(angle_w)
  );

  assign out_angle = angle_w;

endmodule

### hw/rtl/atn_prep.sv
// Input stage: magnitudes, signs and operand ordering for the divider.
// Depends on atn_pkg.
module atn_prep #(
  parameter int COORD_WIDTH = atn_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  output atn_pkg::ctl_t                 ctl_o,
  output logic [COORD_WIDTH-1:0]        min_o,
  output logic [COORD_WIDTH-1:0]        max_o
);
  import atn_pkg::*;

  logic [COORD_WIDTH-1:0] yu, xu, ay, ax;
  side_t                  side_nxt;
  logic                   v_r;
  side_t                  side_r;
  logic [COORD_WIDTH-1:0] min_r, max_r;

  // most negative code maps to 2^(COORD_WIDTH-1), which still fits unsigned
  always_comb begin
    yu = y_coord;
    xu = x_coord;
    ay = yu[COORD_WIDTH-1] ? (~yu + 1'b1) : yu;
    ax = xu[COORD_WIDTH-1] ? (~xu + 1'b1) : xu;
    side_nxt.yneg  = yu[COORD_WIDTH-1];
    side_nxt.xneg  = xu[COORD_WIDTH-1];
    side_nxt.xzero = (ax == '0);
    side_nxt.yzero = (ay == '0);
    side_nxt.swap  = (ay > ax);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      min_r  <= side_nxt.swap ? ax : ay;
      max_r  <= side_nxt.swap ? ay : ax;
    end
  end

  assign ctl_o = '{valid: v_r, side: side_r};
  assign min_o = min_r;
  assign max_o = max_r;

endmodule

### hw/rtl/atn_div.sv
// Pipelined restoring divider: t = (min*2^15 + max/2) / max, one quotient
// bit per stage after a dividend forming stage. Depends on atn_pkg.
module atn_div #(
  parameter int COORD_WIDTH = atn_pkg::DEF_COORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  atn_pkg::ctl_t               ctl_i,
  input  logic [COORD_WIDTH-1:0]      min_i,
  input  logic [COORD_WIDTH-1:0]      max_i,
  output atn_pkg::ctl_t               ctl_o,
  output logic [atn_pkg::RATIO_W-1:0] t_o
);
  import atn_pkg::*;

  localparam int NW    = COORD_WIDTH + RATIO_W;
  localparam int STEPS = RATIO_W;

  logic [NW-1:0]          n_w;
  logic                   v_r    [0:STEPS];
  side_t                  side_r [0:STEPS];
  logic [COORD_WIDTH-1:0] rem_r  [0:STEPS-1];
  logic [COORD_WIDTH-1:0] den_r  [0:STEPS-1];
  logic [RATIO_W-1:0]     low_r  [0:STEPS-1];
  logic [RATIO_W-1:0]     q_r    [1:STEPS];

  assign n_w = NW'({min_i, {RATIO_FRAC{1'b0}}}) + NW'(max_i >> 1);

  // dividend stage: upper part already below the divisor since min <= max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= ctl_i.side;
      rem_r[0]  <= n_w[NW-1:RATIO_W];
      low_r[0]  <= n_w[RATIO_W-1:0];
      den_r[0]  <= max_i;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [COORD_WIDTH:0]   r2, diff;
    logic                   ge;
    logic [RATIO_W-1:0]     q_prev;

    assign r2   = {rem_r[k-1], low_r[k-1][RATIO_W-1]};
    assign diff = r2 - {1'b0, den_r[k-1]};
    assign ge   = (r2 >= {1'b0, den_r[k-1]});

    if (k == 1) begin : g_first
      assign q_prev = '0;
    end else begin : g_rest
      assign q_prev = q_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
        q_r[k]    <= {q_prev[RATIO_W-2:0], ge};
      end
    end

    if (k < STEPS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[COORD_WIDTH-1:0] : r2[COORD_WIDTH-1:0];
          low_r[k] <= low_r[k-1] << 1;
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign ctl_o = '{valid: v_r[STEPS], side: side_r[STEPS]};
  assign t_o   = q_r[STEPS];

endmodule

### hw/rtl/atn_poly.sv
// Odd minimax polynomial for atan(t), Horner's rule in Q1.15, one
// multiplication per stage. Depends on atn_pkg.
module atn_poly (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  atn_pkg::ctl_t              ctl_i,
  input  logic [atn_pkg::RATIO_W-1:0] t_i,
  output atn_pkg::ctl_t              ctl_o,
  output logic [atn_pkg::PROD_W-1:0] prod_o
);
  import atn_pkg::*;

  localparam int NS = 6;

  logic               v_r    [1:NS];
  side_t              side_r [1:NS];
  logic [PROD_W-1:0]  prod_r [1:NS];
  logic [RATIO_W-1:0] t_r    [1:NS-1];
  logic [RATIO_W-1:0] t2_r   [2:NS-2];
  logic [RATIO_W-1:0] t2_nxt;
  logic [PROD_W-1:0]  sq_nxt, inner_nxt;

  assign sq_nxt    = t_i * t_i;
  assign t2_nxt    = rnd15(prod_r[1]);
  assign inner_nxt = COEF_INNER * t2_nxt;

  for (genvar j = 1; j <= NS; j++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= (j == 1) ? ctl_i.valid : v_r[(j == 1) ? 1 : j-1];
      end
    end
  end

  // square, then innermost coefficient
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= ctl_i.side;
      t_r[1]    <= t_i;
      prod_r[1] <= sq_nxt;
      side_r[2] <= side_r[1];
      t_r[2]    <= t_r[1];
      t2_r[2]   <= t2_nxt;
      prod_r[2] <= inner_nxt;
    end
  end

  for (genvar j = 3; j <= NS; j++) begin : g_horner
    logic [RATIO_W-1:0] p, mul;
    logic [PROD_W-1:0]  prod_nxt;

    assign p = HORNER_C[j-3] - rnd15(prod_r[j-1]);
    if (j == NS) begin : g_last
      assign mul = t_r[j-1];
    end else begin : g_mid
      assign mul = t2_r[j-1];
    end
    assign prod_nxt = mul * p;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_r[j-1];
        prod_r[j] <= prod_nxt;
      end
    end

    if (j < NS) begin : g_keep_t
      always_ff @(posedge clk) begin
        if (en) begin
          t_r[j] <= t_r[j-1];
        end
      end
    end

    if (j < NS - 1) begin : g_keep_t2
      always_ff @(posedge clk) begin
        if (en) begin
          t2_r[j] <= t2_r[j-1];
        end
      end
    end
  end

  assign ctl_o  = '{valid: v_r[NS], side: side_r[NS]};
  assign prod_o = prod_r[NS];

endmodule

### hw/rtl/atn_fin.sv
// Output stages: format conversion, half-pi reflection, quadrant fixup,
// saturation and sign. The last stage is the output register. Depends on atn_pkg.
module atn_fin #(
  parameter int ANGLE_FRAC_BITS = atn_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  atn_pkg::ctl_t                ctl_i,
  input  logic [atn_pkg::PROD_W-1:0]   prod_i,
  output logic                         valid_o,
  output logic [ANGLE_FRAC_BITS+2:0]   angle_o
);
  import atn_pkg::*;

  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam logic [63:0]   PI_W  = scaled_pi(61 - ANGLE_FRAC_BITS);
  localparam logic [63:0]   HPI_W = scaled_pi(62 - ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] PI_O  = PI_W[AW-1:0];
  localparam logic [AW-1:0] HPI_O = HPI_W[AW-1:0];

  logic               v_r    [1:4];
  side_t              side_r [1:3];
  logic [RATIO_W-1:0] a15;
  logic [AW-1:0]      a_nxt, base_nxt, mag_nxt, sat;
  logic [AW-1:0]      a_r, base_r, mag_r, angle_r;

  assign a15 = rnd15(prod_i);

  if (ANGLE_FRAC_BITS >= RATIO_FRAC) begin : g_widen
    assign a_nxt = AW'(a15) << (ANGLE_FRAC_BITS - RATIO_FRAC);
  end else begin : g_narrow
    localparam int SH = RATIO_FRAC - ANGLE_FRAC_BITS;
    logic [RATIO_W:0] sum;
    assign sum   = {1'b0, a15} + ((RATIO_W + 1)'(1) << (SH - 1));
    assign a_nxt = AW'(sum >> SH);
  end

  always_comb begin
    if (side_r[1].swap) begin
      base_nxt = (a_r >= HPI_O) ? '0 : HPI_O - a_r;
    end else begin
      base_nxt = a_r;
    end
  end

  // left half-plane folds around pi; x on the axis gives half pi or zero
  always_comb begin
    if (side_r[2].xzero) begin
      mag_nxt = side_r[2].yzero ? '0 : HPI_O;
    end else if (side_r[2].xneg) begin
      mag_nxt = (base_r >= PI_O) ? '0 : PI_O - base_r;
    end else begin
      mag_nxt = base_r;
    end
  end

  assign sat = (mag_r > PI_O) ? PI_O : mag_r;

  for (genvar j = 1; j <= 4; j++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= (j == 1) ? ctl_i.valid : v_r[(j == 1) ? 1 : j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= ctl_i.side;
      a_r       <= a_nxt;
      side_r[2] <= side_r[1];
      base_r    <= base_nxt;
      side_r[3] <= side_r[2];
      mag_r     <= mag_nxt;
      angle_r   <= side_r[3].yneg ? (~sat + 1'b1) : sat;
    end
  end

  assign valid_o = v_r[4];
  assign angle_o = angle_r;

endmodule

### hw/rtl/atn_checker.sv
// Port-level checks for arctangent2_approx and the bind that attaches them.
// Depends on atn_pkg.
module atn_checker #(
  parameter int ANGLE_FRAC_BITS = atn_pkg::DEF_ANGLE_FRAC_BITS
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ANGLE_FRAC_BITS+2:0] out_angle
);
  import atn_pkg::*;

  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam logic [63:0]          PI_W   = scaled_pi(61 - ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] PI_S   = PI_W[AW-1:0];
  localparam logic signed [AW-1:0] NPI_S  = -PI_S;

  logic signed [AW-1:0] angle_s;
  assign angle_s = out_angle;

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle))
    else $error("result changed while stalled");

  // saturation keeps every angle within plus or minus pi
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle_s <= PI_S) && (angle_s >= NPI_S))
    else $error("angle outside plus or minus pi");

  // input backs up only behind a held result
  a_stall: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // reset drains the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind arctangent2_approx atn_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atn_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_angle(out_angle)
);

### bench/arctangent2_approx_tb.sv
// Self-checking bench for arctangent2_approx: drives (y, x) pairs and checks each angle
// against a bit-exact fixed-point atan2 predictor kept in this file.
// Depends on atn_pkg (coordinate/angle widths, pi constant) and the arctangent2_approx RTL.
module arctangent2_approx_tb;
  import atn_pkg::*;

  localparam int CW        = DEF_COORD_WIDTH;
  localparam int FB        = DEF_ANGLE_FRAC_BITS;
  localparam int AW        = DEF_ANGLE_FRAC_BITS + 3;
  localparam int HOLD_LEN  = 300;
  localparam int TAIL_WAIT = 60;
  localparam int LIMIT     = 300000;

  typedef struct {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } pair_t;

  typedef struct {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
    logic signed [AW-1:0] angle;
  } angle_exp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_y_coord = '0;
  logic signed [CW-1:0] in_x_coord = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [AW-1:0] out_angle;

  pair_t      pending_pairs[$];
  angle_exp_t awaited_angles[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  sender_hold = 1'b0;
  int  hold_kicks = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  logic in_taken = 1'b0;

  arctangent2_approx u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_y_coord(in_y_coord),
    .in_x_coord(in_x_coord),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_angle (out_angle)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned round_q15(input longint unsigned v);
    return (v + 64'd16384) >> 15;
  endfunction

  // atan(t) for t in Q1.15 within [0, 1], converted to the output fraction width
  function automatic longint unsigned atan_ratio(input longint unsigned t);
    longint unsigned t2, p, a15;
    t2  = round_q15(t * t);
    p   = 64'd2790 - round_q15(64'd683 * t2);
    p   = 64'd5903 - round_q15(t2 * p);
    p   = 64'd10823 - round_q15(t2 * p);
    p   = 64'd32764 - round_q15(t2 * p);
    a15 = round_q15(t * p);
    if (FB >= 15) return a15 << (FB - 15);
    return (a15 + (64'd1 << (14 - FB))) >> (15 - FB);
  endfunction

  function automatic logic signed [AW-1:0] atan2_q313(input logic signed [CW-1:0] y,
                                                      input logic signed [CW-1:0] x);
    longint          sy, sx;
    longint unsigned ay, ax, pi_o, hpi_o, base, a, mag;
    logic [AW-1:0]   res;
    sy    = y;
    sx    = x;
    ay    = (sy < 0) ? -sy : sy;
    ax    = (sx < 0) ? -sx : sx;
    pi_o  = (PI_Q61 + (64'd1 << (60 - FB))) >> (61 - FB);
    hpi_o = (PI_Q61 + (64'd1 << (61 - FB))) >> (62 - FB);
    if (ax == 0) begin
      mag = (ay == 0) ? 0 : hpi_o;
    end else begin
      if (ay <= ax) begin
        base = atan_ratio(((ay << 15) + (ax >> 1)) / ax);
      end else begin
        // steep vector: use x/y and reflect about half pi
        a    = atan_ratio(((ax << 15) + (ay >> 1)) / ay);
        base = (a >= hpi_o) ? 0 : hpi_o - a;
      end
      if (sx < 0) mag = (base >= pi_o) ? 0 : pi_o - base;
      else mag = base;
    end
    if (mag > pi_o) mag = pi_o;
    res = mag[AW-1:0];
    if (sy < 0) res = -res;
    return res;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(7))
      0, 1, 2: return CW'($urandom);
      3:       return CW'(int'($urandom_range(128)) - 64);
      4: begin
        case ($urandom_range(3))
          0: return {1'b0, {(CW-1){1'b1}}};
          1: return {1'b1, {(CW-2){1'b0}}, 1'b1};
          2: return {1'b1, {(CW-1){1'b0}}};
          default: return '0;
        endcase
      end
      default: return CW'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic offer(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    pair_t pr;
    pr.y = y;
    pr.x = x;
    pending_pairs.push_back(pr);
  endtask

  task automatic offer_random(input int n);
    logic signed [CW-1:0] y, x;
    for (int i = 0; i < n; i++) begin
      y = pick_coord();
      case ($urandom_range(5))
        0: x = ($urandom_range(1) ? y : -y) + CW'(int'($urandom_range(4)) - 2);
        1: begin
          x = pick_coord();
          if ($urandom_range(1)) y = '0;
          else x = '0;
        end
        default: x = pick_coord();
      endcase
      offer(y, x);
    end
  endtask

  // hold new transfers back until every awaited angle has arrived
  task automatic drain();
    sender_hold = 1'b1;
    while (in_valid || awaited_angles.size() != 0) @(posedge clk);
    sender_hold = 1'b0;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input bit kick);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    offer_random(n);
    if (kick) begin
      repeat (50) @(posedge clk);
      hold_kicks++;
    end
    while (pending_pairs.size() != 0) @(posedge clk);
    drain();
  endtask

  // sender: present a new pair once the previous one has transferred
  always @(negedge clk) begin
    pair_t pr;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_pairs.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        pr = pending_pairs.pop_front();
        in_valid   <= 1'b1;
        in_y_coord <= pr.y;
        in_x_coord <= pr.x;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on each kick
  always @(negedge clk) begin
    static int hold_served = 0;
    static int hold_left = 0;
    if (hold_served != hold_kicks) begin
      hold_served = hold_kicks;
      hold_left   = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    angle_exp_t ex;
    cycle_count++;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        ex.y     = in_y_coord;
        ex.x     = in_x_coord;
        ex.angle = atan2_q313(in_y_coord, in_x_coord);
        awaited_angles.push_back(ex);
      end
      if (out_valid && !out_stall) begin
        if (awaited_angles.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected angle transfer: %0d", out_angle);
          mismatch_count++;
        end else begin
          ex = awaited_angles.pop_front();
          if (out_angle !== ex.angle) begin
            if (mismatch_count < 10)
              $display("angle mismatch y=%0d x=%0d: expected %0d got %0d",
                       ex.y, ex.x, ex.angle, out_angle);
            mismatch_count++;
          end
        end
      end
    end
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // axes, origin, diagonals, most negative code, near-pi overshoot
    offer(16'sd0, 16'sd0);
    offer(16'sd1, 16'sd0);
    offer(-16'sd1, 16'sd0);
    offer(16'sd32767, 16'sd0);
    offer(-16'sd32768, 16'sd0);
    offer(16'sd0, 16'sd32767);
    offer(16'sd0, -16'sd32767);
    offer(16'sd0, -16'sd32768);
    offer(16'sd0, 16'sd1);
    offer(16'sd32767, 16'sd32767);
    offer(-16'sd32767, -16'sd32767);
    offer(16'sd1, -16'sd1);
    offer(-16'sd32768, -16'sd32768);
    offer(-16'sd32768, 16'sd32767);
    offer(16'sd32767, -16'sd32768);
    offer(16'sd1, 16'sd32767);
    offer(16'sd32767, 16'sd1);
    offer(-16'sd1, -16'sd32767);
    offer(16'sd1, -16'sd32767);
    offer(-16'sd32768, 16'sd1);
    offer(16'sd100, -16'sd200);
    offer(-16'sd3, 16'sd5);
    offer(16'sd32767, -16'sd32767);
    while (pending_pairs.size() != 0) @(posedge clk);
    drain();

    run_phase(400, 0, 0, 1'b1);
    run_phase(400, 60, 0, 1'b0);
    run_phase(400, 0, 60, 1'b0);
    run_phase(400, 13, 13, 1'b0);

    recv_stall_pct = 0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
